// File: sv/css_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_pkg
// Types, codes and constants shared by the charge session sequencer.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int CFG_DW = 10;
  localparam int CFG_AW = 3;
  localparam int IN_DW  = 48;
  localparam int OUT_DW = 32;

  // Monitor check schedule, in ticks within one check period
  localparam logic [8:0] CHECK_PERIOD     = 9'd200;
  localparam logic [7:0] AT_CURRENT_CHECK = 8'd150;
  localparam logic [7:0] AT_SOC_CHECK     = 8'd160;
  localparam logic [7:0] AT_RAMP_CHECK    = 8'd180;

  // Register indexes on the configuration port
  localparam logic [CFG_AW-1:0] REG_STOP_SOC    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_INIT_CUR    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CUR_STEP    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CUR_CAP     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MIN_MAX     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_ARM_OUT_WT  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_ARM_IN_WT   = 3'd6;
  localparam logic [CFG_AW-1:0] REG_ARM_REPEATS = 3'd7;

  typedef enum logic [8:0] {
    ST_START    = 9'b0_0000_0001,
    ST_ARM_OUT  = 9'b0_0000_0010,
    ST_WAIT_OUT = 9'b0_0000_0100,
    ST_APPLY    = 9'b0_0000_1000,
    ST_MONITOR  = 9'b0_0001_0000,
    ST_ARM_IN   = 9'b0_0010_0000,
    ST_WAIT_IN  = 9'b0_0100_0000,
    ST_STOP     = 9'b0_1000_0000,
    ST_OVER     = 9'b1_0000_0000
  } stage_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_BAT_START = 3'd1,
    CMD_ARM_OUT   = 3'd2,
    CMD_APPLY     = 3'd3,
    CMD_ARM_IN    = 3'd4,
    CMD_BAT_STOP  = 3'd5,
    CMD_RELEASE   = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [7:0] stop_soc_level;
    logic [9:0] initial_current;
    logic [7:0] current_step;
    logic [9:0] current_cap;
    logic [9:0] min_allowed_max;
    logic [7:0] arm_out_wait_ticks;
    logic [7:0] arm_in_wait_ticks;
    logic [3:0] arm_repeats;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    stop_soc_level:     8'd85,
    initial_current:    10'd20,
    current_step:       8'd10,
    current_cap:        10'd120,
    min_allowed_max:    10'd10,
    arm_out_wait_ticks: 8'd150,
    arm_in_wait_ticks:  8'd60,
    arm_repeats:        4'd3
  };

  typedef struct packed {
    stage_t     stage;
    logic [7:0] tick_count;
    logic [1:0] neg_current_count;
    logic [1:0] soc_over_count;
    logic [9:0] charge_setpoint;
    logic       running;
  } seq_state_t;

  // Last member sits in the lowest bits
  typedef struct packed {
    logic [15:0] battery_max_current;
    logic        max_valid;
    logic [7:0]  soc_reading;
    logic        soc_valid;
    logic [15:0] battery_current;
    logic        current_valid;
    logic        stop_request;
    logic        start_req;
  } tick_in_t;

  typedef struct packed {
    logic       finished;
    logic [3:0] stage_out;
    logic       max_current_write;
    logic [9:0] max_current_out;
    logic [9:0] current_setpoint;
    cmd_t       command;
  } tick_out_t;

  function automatic logic [3:0] stage_num(input stage_t s);
    logic [3:0] n;
    unique case (s)
      ST_START:    n = 4'd0;
      ST_ARM_OUT:  n = 4'd1;
      ST_WAIT_OUT: n = 4'd2;
      ST_APPLY:    n = 4'd3;
      ST_MONITOR:  n = 4'd4;
      ST_ARM_IN:   n = 4'd5;
      ST_WAIT_IN:  n = 4'd6;
      ST_STOP:     n = 4'd7;
      ST_OVER:     n = 4'd8;
      default:     n = 4'd9;
    endcase
    return n;
  endfunction

endpackage

// File: sv/css_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_step
// Next-state and result logic for one control tick of the session sequencer.
// ----------------------------------------------------------------------------
module css_step
  import css_pkg::*;
(
  input  cfg_t       cfg,
  input  seq_state_t cur,
  input  tick_in_t   tin,
  output seq_state_t nxt,
  output tick_out_t  res
);

  always_comb begin
    seq_state_t s;
    cmd_t       cmd;
    logic [9:0] mx;
    logic       mxw;
    logic [8:0] tick_wide;
    logic [9:0] m_clip;
    logic [10:0] ramp_sum;
    logic       leave;

    s         = cur;
    cmd       = CMD_NONE;
    mx        = '0;
    mxw       = 1'b0;
    tick_wide = '0;
    m_clip    = '0;
    ramp_sum  = '0;
    leave     = 1'b0;

    // Re-arm after the session is over
    if (!cur.running && tin.start_req) begin
      s.running           = 1'b1;
      s.stage             = ST_START;
      s.tick_count        = '0;
      s.neg_current_count = '0;
      s.soc_over_count    = '0;
    end

    if (s.running) begin
      // Stop request jumps to retraction; fault counters are kept
      if (tin.stop_request) begin
        s.tick_count = '0;
        s.stage      = ST_ARM_IN;
      end

      unique case (s.stage)
        ST_START: begin
          cmd               = CMD_BAT_START;
          s.charge_setpoint = cfg.initial_current;
          s.stage           = ST_ARM_OUT;
        end
        ST_ARM_OUT: begin
          if (s.tick_count < {4'd0, cfg.arm_repeats}) begin
            cmd          = CMD_ARM_OUT;
            s.tick_count = s.tick_count + 8'd1;
          end else begin
            s.tick_count = '0;
            s.stage      = ST_WAIT_OUT;
          end
        end
        ST_WAIT_OUT: begin
          if (s.tick_count < cfg.arm_out_wait_ticks) begin
            s.tick_count = s.tick_count + 8'd1;
          end else begin
            s.tick_count = '0;
            s.stage      = ST_APPLY;
          end
        end
        ST_APPLY: begin
          cmd          = CMD_APPLY;
          s.tick_count = '0;
          s.stage      = ST_MONITOR;
        end
        ST_MONITOR: begin
          tick_wide = {1'b0, s.tick_count} + 9'd1;
          if (tick_wide >= CHECK_PERIOD) begin
            s.tick_count = '0;
          end else begin
            s.tick_count = tick_wide[7:0];
          end

          if (s.tick_count == AT_CURRENT_CHECK) begin
            if (tin.current_valid) begin
              if (tin.battery_current[15]) begin
                s.neg_current_count = s.neg_current_count + 2'd1;
                // Two discharging readings in a row: cut current, retract
                if (s.neg_current_count == 2'd2) begin
                  s.charge_setpoint = '0;
                  cmd               = CMD_APPLY;
                  leave             = 1'b1;
                end
              end else begin
                s.neg_current_count = '0;
              end
            end
          end else if (s.tick_count == AT_SOC_CHECK) begin
            if (tin.soc_valid) begin
              if (tin.soc_reading > cfg.stop_soc_level) begin
                s.soc_over_count = s.soc_over_count + 2'd1;
                if (s.soc_over_count == 2'd2) begin
                  leave = 1'b1;
                end
              end else begin
                s.soc_over_count = '0;
              end
            end
          end else if (s.tick_count == AT_RAMP_CHECK) begin
            if (tin.max_valid) begin
              if (tin.battery_max_current <= {6'd0, cfg.min_allowed_max}) begin
                leave = 1'b1;
              end else begin
                if (tin.battery_max_current > {6'd0, cfg.current_cap}) begin
                  m_clip = cfg.current_cap;
                end else begin
                  m_clip = tin.battery_max_current[9:0];
                end
                mx       = m_clip;
                mxw      = 1'b1;
                ramp_sum = {1'b0, s.charge_setpoint} + {3'd0, cfg.current_step};
                if (ramp_sum < {1'b0, m_clip}) begin
                  s.charge_setpoint = ramp_sum[9:0];
                  cmd               = CMD_APPLY;
                end else if (s.charge_setpoint > m_clip) begin
                  // Step down, saturating at zero
                  if (s.charge_setpoint > {2'd0, cfg.current_step}) begin
                    s.charge_setpoint = s.charge_setpoint - {2'd0, cfg.current_step};
                  end else begin
                    s.charge_setpoint = '0;
                  end
                  cmd = CMD_APPLY;
                end
              end
            end
          end

          if (leave) begin
            s.tick_count        = '0;
            s.neg_current_count = '0;
            s.soc_over_count    = '0;
            s.stage             = ST_ARM_IN;
          end
        end
        ST_ARM_IN: begin
          if (s.tick_count < {4'd0, cfg.arm_repeats}) begin
            cmd          = CMD_ARM_IN;
            s.tick_count = s.tick_count + 8'd1;
          end else begin
            s.tick_count = '0;
            s.stage      = ST_WAIT_IN;
          end
        end
        ST_WAIT_IN: begin
          if (s.tick_count < cfg.arm_in_wait_ticks) begin
            s.tick_count = s.tick_count + 8'd1;
          end else begin
            s.tick_count = '0;
            s.stage      = ST_STOP;
          end
        end
        ST_STOP: begin
          cmd     = CMD_BAT_STOP;
          s.stage = ST_OVER;
        end
        ST_OVER: begin
          cmd       = CMD_RELEASE;
          s.running = 1'b0;
        end
        default: begin
          cmd = CMD_NONE;
        end
      endcase
    end

    nxt                   = s;
    res.command           = cmd;
    res.current_setpoint  = s.charge_setpoint;
    res.max_current_out   = mx;
    res.max_current_write = mxw;
    res.stage_out         = stage_num(s.stage);
    res.finished          = (s.stage == ST_OVER);
  end

endmodule

// File: sv/charge_session_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charge_session_sequencer
// Walks one charging session through its stages, one command per control tick.
// ----------------------------------------------------------------------------
// The result for an item is registered in res_q and is on m_tdata in the cycle after the item is taken.
// One item per cycle while m_tready takes each result; the session state updates as each item is taken.
// A held result that is not taken holds s_tready low until m_tready takes it.
// Reset (rst, synchronous): start stage, counters and setpoint zero, running,
// configuration registers back to their defaults, no result pending.
module charge_session_sequencer
  import css_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // start_req, stop_request, current_valid, battery_current[15:0], soc_valid,
  // soc_reading[7:0], max_valid, battery_max_current[15:0], zero pad
  input  logic [IN_DW-1:0]  s_tdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  // command[2:0], current_setpoint[9:0], max_current_out[9:0],
  // max_current_write, stage_out[3:0], finished, zero pad
  output logic [OUT_DW-1:0] m_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  tick_in_t   tin;
  tick_out_t  res;
  tick_out_t  res_q;
  logic       take;

  assign tin      = tick_in_t'(s_tdata[$bits(tick_in_t)-1:0]);
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;
  assign m_tdata  = {{(OUT_DW-$bits(tick_out_t)){1'b0}}, res_q};

  css_step u_step (
    .cfg (cfg),
    .cur (state),
    .tin (tin),
    .nxt (state_next),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STOP_SOC:    cfg.stop_soc_level     <= cfg_data[7:0];
        REG_INIT_CUR:    cfg.initial_current    <= cfg_data;
        REG_CUR_STEP:    cfg.current_step       <= cfg_data[7:0];
        REG_CUR_CAP:     cfg.current_cap        <= cfg_data;
        REG_MIN_MAX:     cfg.min_allowed_max    <= cfg_data;
        REG_ARM_OUT_WT:  cfg.arm_out_wait_ticks <= cfg_data[7:0];
        REG_ARM_IN_WT:   cfg.arm_in_wait_ticks  <= cfg_data[7:0];
        REG_ARM_REPEATS: cfg.arm_repeats        <= cfg_data[3:0];
        default:         cfg                    <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.stage             <= ST_START;
      state.tick_count        <= '0;
      state.neg_current_count <= '0;
      state.soc_over_count    <= '0;
      state.charge_setpoint   <= '0;
      state.running           <= 1'b1;
    end else if (take) begin
      state <= state_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res;
    end
  end

endmodule

// File: tb/tb_charge_session_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_charge_session_sequencer
// Self-checking bench for the charge session sequencer. Control ticks go in
// on the slave stream and are mirrored by a behavioural session model. Each
// result on the master stream is compared field by field with the oldest
// predicted tick. The run covers a short directed walk through every stage:
// stop requests in the stop and over stages, idle ticks after release, and a
// restart. It then runs randomised sessions under several register settings,
// extremes included, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_charge_session_sequencer;
  import css_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // Stage numbers as they appear on stage_out
  typedef enum logic [3:0] {
    S_START, S_ARM_OUT, S_WAIT_OUT, S_APPLY, S_MONITOR,
    S_ARM_IN, S_WAIT_IN, S_STOP, S_OVER
  } stage_idx_t;

  class session_scoreboard;
    cfg_t        cfg;
    stage_idx_t  stage;
    int unsigned ticks;
    int unsigned neg_faults;
    int unsigned soc_faults;
    int unsigned setpoint;
    bit          running;
    tick_out_t   expected_q[$];
    int unsigned mismatches, checked, released;
    int unsigned neg_trips, soc_trips, low_max_stops, ramp_moves;

    function new();
      cfg     = CFG_RESET;
      stage   = S_START;
      running = 1'b1;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void retract_arm();
      ticks      = 0;
      neg_faults = 0;
      soc_faults = 0;
      stage      = S_ARM_IN;
    endfunction

    // Advance the session by one accepted tick and queue the result it causes
    function void note_tick(tick_in_t t);
      tick_out_t   r;
      cmd_t        cmd;
      logic [9:0]  mx;
      bit          mxw;
      int unsigned m;
      cmd = CMD_NONE;
      mx  = '0;
      mxw = 1'b0;
      if (!running && t.start_req) begin
        running    = 1'b1;
        stage      = S_START;
        ticks      = 0;
        neg_faults = 0;
        soc_faults = 0;
      end
      if (running) begin
        if (t.stop_request) begin
          ticks = 0;
          stage = S_ARM_IN;
        end
        case (stage)
          S_START: begin
            cmd      = CMD_BAT_START;
            setpoint = cfg.initial_current;
            stage    = S_ARM_OUT;
          end
          S_ARM_OUT: begin
            if (ticks < cfg.arm_repeats) begin
              cmd = CMD_ARM_OUT;
              ticks++;
            end else begin
              ticks = 0;
              stage = S_WAIT_OUT;
            end
          end
          S_WAIT_OUT: begin
            if (ticks < cfg.arm_out_wait_ticks) ticks++;
            else begin
              ticks = 0;
              stage = S_APPLY;
            end
          end
          S_APPLY: begin
            cmd   = CMD_APPLY;
            ticks = 0;
            stage = S_MONITOR;
          end
          S_MONITOR: begin
            ticks = (ticks + 1 >= CHECK_PERIOD) ? 0 : ticks + 1;
            if (ticks == AT_CURRENT_CHECK) begin
              if (t.current_valid) begin
                if (t.battery_current[15]) begin
                  neg_faults = (neg_faults + 1) & 3;
                  if (neg_faults == 2) begin
                    setpoint = 0;
                    cmd      = CMD_APPLY;
                    neg_trips++;
                    retract_arm();
                  end
                end else begin
                  neg_faults = 0;
                end
              end
            end else if (ticks == AT_SOC_CHECK) begin
              if (t.soc_valid) begin
                if (t.soc_reading > cfg.stop_soc_level) begin
                  soc_faults = (soc_faults + 1) & 3;
                  if (soc_faults == 2) begin
                    soc_trips++;
                    retract_arm();
                  end
                end else begin
                  soc_faults = 0;
                end
              end
            end else if (ticks == AT_RAMP_CHECK && t.max_valid) begin
              m = t.battery_max_current;
              if (m <= cfg.min_allowed_max) begin
                low_max_stops++;
                retract_arm();
              end else begin
                if (m > cfg.current_cap) m = cfg.current_cap;
                mx  = m[9:0];
                mxw = 1'b1;
                if (setpoint + cfg.current_step < m) begin
                  setpoint += cfg.current_step;
                  cmd = CMD_APPLY;
                  ramp_moves++;
                end else if (setpoint > m) begin
                  // saturate at zero on the way down
                  setpoint = (setpoint > cfg.current_step) ? setpoint - cfg.current_step : 0;
                  cmd = CMD_APPLY;
                  ramp_moves++;
                end
              end
            end
          end
          S_ARM_IN: begin
            if (ticks < cfg.arm_repeats) begin
              cmd = CMD_ARM_IN;
              ticks++;
            end else begin
              ticks = 0;
              stage = S_WAIT_IN;
            end
          end
          S_WAIT_IN: begin
            if (ticks < cfg.arm_in_wait_ticks) ticks++;
            else begin
              ticks = 0;
              stage = S_STOP;
            end
          end
          S_STOP: begin
            cmd   = CMD_BAT_STOP;
            stage = S_OVER;
          end
          S_OVER: begin
            cmd     = CMD_RELEASE;
            running = 1'b0;
            released++;
          end
          default: ;
        endcase
      end
      r.command           = cmd;
      r.current_setpoint  = setpoint[9:0];
      r.max_current_out   = mx;
      r.max_current_write = mxw;
      r.stage_out         = stage;
      r.finished          = (stage == S_OVER);
      expected_q = {expected_q, r};
    endfunction

    function void check_result(tick_out_t got);
      tick_out_t want;
      if (expected_q.size() == 0) begin
        $error("result %h arrived with no tick outstanding", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.command !== want.command) begin
        $error("command: expected %0d, got %0d", want.command, got.command);
        mismatches++;
      end
      if (got.current_setpoint !== want.current_setpoint) begin
        $error("current_setpoint: expected %0d, got %0d",
               want.current_setpoint, got.current_setpoint);
        mismatches++;
      end
      if (got.max_current_out !== want.max_current_out) begin
        $error("max_current_out: expected %0d, got %0d",
               want.max_current_out, got.max_current_out);
        mismatches++;
      end
      if (got.max_current_write !== want.max_current_write) begin
        $error("max_current_write: expected %0d, got %0d",
               want.max_current_write, got.max_current_write);
        mismatches++;
      end
      if (got.stage_out !== want.stage_out) begin
        $error("stage_out: expected %0d, got %0d", want.stage_out, got.stage_out);
        mismatches++;
      end
      if (got.finished !== want.finished) begin
        $error("finished: expected %0d, got %0d", want.finished, got.finished);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [IN_DW-1:0]  s_tdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [OUT_DW-1:0] m_tdata;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  session_scoreboard sb = new();
  bit steady = 1'b0;
  int unsigned cycles = 0;

  charge_session_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= steady || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(tick_out_t'(m_tdata[$bits(tick_out_t)-1:0]));
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycles, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // Hold the item until taken, then idle now and then
  task automatic send_tick(input tick_in_t t);
    s_tdata  <= {{(IN_DW - $bits(tick_in_t)){1'b0}}, t};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_tick(t);
    if (!steady && $urandom_range(0, 99) < 37) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 37);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    logic [CFG_DW-1:0] vals [8];
    vals[REG_STOP_SOC]    = CFG_DW'(c.stop_soc_level);
    vals[REG_INIT_CUR]    = c.initial_current;
    vals[REG_CUR_STEP]    = CFG_DW'(c.current_step);
    vals[REG_CUR_CAP]     = c.current_cap;
    vals[REG_MIN_MAX]     = c.min_allowed_max;
    vals[REG_ARM_OUT_WT]  = CFG_DW'(c.arm_out_wait_ticks);
    vals[REG_ARM_IN_WT]   = CFG_DW'(c.arm_in_wait_ticks);
    vals[REG_ARM_REPEATS] = CFG_DW'(c.arm_repeats);
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= CFG_AW'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sb.cfg = c;
  endtask

  function automatic tick_in_t directed_tick(int k, bit start, bit stop);
    logic [15:0] cur_x [4] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
    logic [7:0]  soc_x [4] = '{8'd0, 8'd255, 8'd85, 8'd86};
    logic [15:0] max_x [4] = '{16'd0, 16'hFFFF, 16'd10, 16'd11};
    tick_in_t t;
    t.start_req           = start;
    t.stop_request        = stop;
    t.current_valid       = (k % 3 != 2);
    t.battery_current     = cur_x[k % 4];
    t.soc_valid           = (k % 3 != 1);
    t.soc_reading         = soc_x[(k + 1) % 4];
    t.max_valid           = (k % 3 != 0);
    t.battery_max_current = max_x[(k + 2) % 4];
    return t;
  endfunction

  // Mostly undisturbed sessions; readings cluster near the decision points
  function automatic tick_in_t random_tick(input cfg_t c);
    tick_in_t t;
    int unsigned pick;
    t.start_req       = 1'($urandom_range(0, 1));
    t.stop_request    = ($urandom_range(0, 299) == 0);
    t.current_valid   = ($urandom_range(0, 9) != 0);
    t.battery_current = 16'($urandom);
    t.soc_valid       = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 1)) t.soc_reading = 8'($urandom);
    else t.soc_reading = 8'(c.stop_soc_level + $urandom_range(0, 2) - 1);
    t.max_valid = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 9);
    if (pick == 0) t.battery_max_current = 16'($urandom_range(0, c.min_allowed_max + 8));
    else if (pick < 4) t.battery_max_current = 16'($urandom);
    else t.battery_max_current = 16'($urandom_range(0, 1100));
    return t;
  endfunction

  function automatic cfg_t phase_settings(int p);
    cfg_t c;
    c = CFG_RESET;
    case (p)
      0: begin
        c.stop_soc_level     = 8'd255;
        c.initial_current    = 10'd1023;
        c.current_step       = 8'd255;
        c.current_cap        = 10'd1023;
        c.min_allowed_max    = 10'd0;
        c.arm_out_wait_ticks = 8'd0;
        c.arm_in_wait_ticks  = 8'd0;
        c.arm_repeats        = 4'd15;
      end
      1: begin
        c.stop_soc_level     = 8'd0;
        c.initial_current    = 10'd0;
        c.current_step       = 8'd1;
        c.current_cap        = 10'd0;
        c.min_allowed_max    = 10'd1023;
        c.arm_out_wait_ticks = 8'd255;
        c.arm_in_wait_ticks  = 8'd255;
        c.arm_repeats        = 4'd0;
      end
      2: begin
        // small setpoint, large step: ramp down bottoms out at zero
        c.stop_soc_level     = 8'd200;
        c.initial_current    = 10'd5;
        c.current_step       = 8'd200;
        c.current_cap        = 10'd500;
        c.min_allowed_max    = 10'd0;
        c.arm_out_wait_ticks = 8'd3;
        c.arm_in_wait_ticks  = 8'd2;
        c.arm_repeats        = 4'd2;
      end
      3: begin
        c.stop_soc_level     = 8'($urandom_range(0, 255));
        c.initial_current    = 10'($urandom_range(0, 1023));
        c.current_step       = 8'($urandom_range(1, 255));
        c.current_cap        = 10'($urandom_range(0, 1023));
        c.min_allowed_max    = 10'($urandom_range(0, 1023));
        c.arm_out_wait_ticks = 8'($urandom_range(0, 255));
        c.arm_in_wait_ticks  = 8'($urandom_range(0, 255));
        c.arm_repeats        = 4'($urandom_range(0, 15));
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    // bit 1 start_req, bit 0 stop_request
    logic [1:0] plan [21] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0,
                              2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0,
                              2'd0, 2'd0, 2'd0, 2'd1, 2'd3};
    int phase_len [5] = '{300, 450, 300, 300, 250};
    cfg_t c;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // opening ticks run on the reset register values
    for (int k = 0; k < 5; k++) send_tick(directed_tick(k, 1'b0, 1'b0));
    drain();
    c = CFG_RESET;
    c.arm_repeats        = 4'd1;
    c.arm_out_wait_ticks = 8'd1;
    c.arm_in_wait_ticks  = 8'd1;
    load_settings(c);
    foreach (plan[k]) send_tick(directed_tick(k + 5, plan[k][1], plan[k][0]));
    drain();

    for (int p = 0; p < 5; p++) begin
      c = phase_settings(p);
      load_settings(c);
      steady = (p == 0);
      repeat (phase_len[p]) send_tick(random_tick(c));
      drain();
    end
    repeat (4) @(posedge clk);

    $display("%0d ticks checked across %0d released sessions",
             sb.checked, sb.released);
    $display("monitor exits: %0d reverse-current, %0d full-charge, %0d low-maximum; %0d ramp steps",
             sb.neg_trips, sb.soc_trips, sb.low_max_stops, sb.ramp_moves);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
